// File: hw/rtl/mod_pkg.sv
// Package for the mouth opening detector: widths, pipeline depths and payload types.
// Used by the req and rsp interfaces and all detector modules; depends on nothing.
package mod_pkg;
   localparam int COORD_WIDTH = 16;
   localparam int SQ_WIDTH = 2 * COORD_WIDTH + 1;
   localparam int RAD_WIDTH = SQ_WIDTH + 8;
   localparam int DIST_WIDTH = (RAD_WIDTH + 1) / 2;
   localparam int ROOT_STEPS = DIST_WIDTH;
   localparam int T_WIDTH = DIST_WIDTH + 5;
   localparam int NUM_WIDTH = DIST_WIDTH + 13;
   localparam int QUO_STEPS = NUM_WIDTH;
   localparam int RATIO_WIDTH = 16;
   localparam int NUM_LANES = 4;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] upper_outer_x;
      logic [COORD_WIDTH-1:0] upper_outer_y;
      logic [COORD_WIDTH-1:0] upper_inner_x;
      logic [COORD_WIDTH-1:0] upper_inner_y;
      logic [COORD_WIDTH-1:0] lower_outer_x;
      logic [COORD_WIDTH-1:0] lower_outer_y;
      logic [COORD_WIDTH-1:0] lower_inner_x;
      logic [COORD_WIDTH-1:0] lower_inner_y;
      logic [COORD_WIDTH-1:0] left_corner_x;
      logic [COORD_WIDTH-1:0] left_corner_y;
      logic [COORD_WIDTH-1:0] right_corner_x;
      logic [COORD_WIDTH-1:0] right_corner_y;
   } req_type;

   typedef struct packed {
      logic                   mouth_open;
      logic [RATIO_WIDTH-1:0] open_ratio;
   } rsp_type;
endpackage

// File: hw/rtl/mod_if.sv
// Valid/ready channel interfaces for the detector's request, response and register ports.
// Depends on mod_pkg.
interface mod_req_if;
   import mod_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mod_rsp_if;
   import mod_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mod_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/mouth_open_detector_top.sv
// Top level of the mouth opening detector: four distance lanes, the merging divider,
// a valid pipeline and the output register. Depends on mod_pkg, mod_if and submodules.
//
// Usage: a landmark set of twelve Q12.4 coordinates enters on the req channel as one
// item; one result item (mouth_open, open_ratio) leaves on the rsp channel per item.
// The threshold register is written through the csr channel, which is always ready.
// Throughput is one item per cycle while the receiver takes results. Each item passes
// the difference and square-sum registers and the bit-per-stage square root in each
// lane, the divisor register and the bit-per-stage divider, then the output register.
// The whole pipeline advances only when the output register is empty or being
// taken, so a stalled receiver holds every item in place and req_ready falls.
// Reset clears the valid bits and sets the threshold to 1.0 (256 in Q8.8).
module mouth_open_detector_top (
   input logic clock,
   input logic reset,
   mod_req_if.sink   req,
   mod_rsp_if.source rsp,
   mod_csr_if.sink   csr
);
   import mod_pkg::*;

   localparam int DEPTH = 2 + ROOT_STEPS + 1 + QUO_STEPS;

   logic [DEPTH-1:0]       vld_ff, vld_in;
   logic                   out_vld_ff;
   rsp_type                out_ff, merged;
   logic [RATIO_WIDTH-1:0] thr_ff;
   logic                   advance;
   logic [DIST_WIDTH-1:0]  lane_dist [NUM_LANES];

   assign advance = !out_vld_ff || rsp.ready;
   assign req.ready = advance;
   assign csr.ready = 1'b1;
   assign rsp.valid = out_vld_ff;
   assign rsp.payload = out_ff;
   assign vld_in = {vld_ff[DEPTH-2:0], req.valid};

   mod_dist_lane u_up (.clock, .enable(advance),
      .ax(req.payload.upper_outer_x), .ay(req.payload.upper_outer_y),
      .bx(req.payload.upper_inner_x), .by(req.payload.upper_inner_y),
      .distance(lane_dist[0]));
   mod_dist_lane u_low (.clock, .enable(advance),
      .ax(req.payload.lower_outer_x), .ay(req.payload.lower_outer_y),
      .bx(req.payload.lower_inner_x), .by(req.payload.lower_inner_y),
      .distance(lane_dist[1]));
   mod_dist_lane u_gap (.clock, .enable(advance),
      .ax(req.payload.upper_inner_x), .ay(req.payload.upper_inner_y),
      .bx(req.payload.lower_inner_x), .by(req.payload.lower_inner_y),
      .distance(lane_dist[2]));
   mod_dist_lane u_cor (.clock, .enable(advance),
      .ax(req.payload.left_corner_x), .ay(req.payload.left_corner_y),
      .bx(req.payload.right_corner_x), .by(req.payload.right_corner_y),
      .distance(lane_dist[3]));

   mod_ratio_merge u_merge (.clock, .enable(advance), .d_up(lane_dist[0]),
      .d_low(lane_dist[1]), .d_gap(lane_dist[2]), .d_cor(lane_dist[3]),
      .threshold(thr_ff), .result(merged));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
         thr_ff <= RATIO_WIDTH'(256);
      end else begin
         if (csr.valid) begin
            thr_ff <= csr.data;
         end
         if (advance) begin
            vld_ff <= vld_in;
            out_vld_ff <= vld_ff[DEPTH-1];
            out_ff <= merged;
         end
      end
   end
endmodule

// File: hw/rtl/mod_dist_lane.sv
// One distance lane: squares the coordinate differences and takes a pipelined square root.
// Depends on mod_pkg.
module mod_dist_lane (
   input  logic                            clock,
   input  logic                            enable,
   input  logic [mod_pkg::COORD_WIDTH-1:0] ax,
   input  logic [mod_pkg::COORD_WIDTH-1:0] ay,
   input  logic [mod_pkg::COORD_WIDTH-1:0] bx,
   input  logic [mod_pkg::COORD_WIDTH-1:0] by,
   output logic [mod_pkg::DIST_WIDTH-1:0]  distance
);
   import mod_pkg::*;

   logic [COORD_WIDTH-1:0] dx_ff, dy_ff;
   logic [SQ_WIDTH-1:0]    sum_ff;
   logic [2*DIST_WIDTH-1:0] rad_ff [ROOT_STEPS+1];
   logic [DIST_WIDTH+1:0]  rem_ff [ROOT_STEPS+1];
   logic [DIST_WIDTH-1:0]  root_ff [ROOT_STEPS+1];

   always_ff @(posedge clock) begin
      if (enable) begin
         dx_ff <= (ax > bx) ? ax - bx : bx - ax;
         dy_ff <= (ay > by) ? ay - by : by - ay;
         sum_ff <= SQ_WIDTH'({{COORD_WIDTH{1'b0}}, dx_ff} * {{COORD_WIDTH{1'b0}}, dx_ff})
                 + SQ_WIDTH'({{COORD_WIDTH{1'b0}}, dy_ff} * {{COORD_WIDTH{1'b0}}, dy_ff});
      end
   end

   always_comb begin
      rad_ff[0] = (2*DIST_WIDTH)'({sum_ff, 8'd0});
      rem_ff[0] = '0;
      root_ff[0] = '0;
   end

   for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
      logic [DIST_WIDTH+1:0] rem_in, trial_in;
      always_comb begin
         rem_in = {rem_ff[s][DIST_WIDTH-1:0], rad_ff[s][2*DIST_WIDTH-1 -: 2]};
         trial_in = {root_ff[s], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rad_ff[s+1] <= {rad_ff[s][2*DIST_WIDTH-3:0], 2'b00};
            if (rem_in >= trial_in) begin
               rem_ff[s+1] <= rem_in - trial_in;
               root_ff[s+1] <= {root_ff[s][DIST_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= rem_in;
               root_ff[s+1] <= {root_ff[s][DIST_WIDTH-2:0], 1'b0};
            end
         end
      end
   end

   assign distance = root_ff[ROOT_STEPS];
endmodule

// File: hw/rtl/mod_ratio_merge.sv
// Merging stage: combines the four lane distances into the capped thickness, then a
// pipelined restoring divider forms the Q8.8 ratio and the open flag. Depends on mod_pkg.
module mod_ratio_merge (
   input  logic                             clock,
   input  logic                             enable,
   input  logic [mod_pkg::DIST_WIDTH-1:0]   d_up,
   input  logic [mod_pkg::DIST_WIDTH-1:0]   d_low,
   input  logic [mod_pkg::DIST_WIDTH-1:0]   d_gap,
   input  logic [mod_pkg::DIST_WIDTH-1:0]   d_cor,
   input  logic [mod_pkg::RATIO_WIDTH-1:0]  threshold,
   output mod_pkg::rsp_type                 result
);
   import mod_pkg::*;

   logic [T_WIDTH-1:0]   div_ff [QUO_STEPS+1];
   logic [NUM_WIDTH-1:0] num_ff [QUO_STEPS+1];
   logic [T_WIDTH:0]     rem_ff [QUO_STEPS+1];
   logic [NUM_WIDTH-1:0] quo_ff [QUO_STEPS+1];
   logic                 nz_ff [QUO_STEPS+1];
   logic [T_WIDTH-1:0]   t_avg, t_cap;
   logic                 sat;

   always_comb begin
      t_avg = T_WIDTH'(9) * T_WIDTH'({1'b0, d_up} + {1'b0, d_low});
      t_cap = T_WIDTH'({d_cor, 2'b00});
      rem_ff[0] = '0;
      quo_ff[0] = '0;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         div_ff[0] <= (t_cap < t_avg) ? t_cap : t_avg;
         num_ff[0] <= NUM_WIDTH'(d_gap) * NUM_WIDTH'(4608);
         nz_ff[0] <= d_gap != '0;
      end
   end

   for (genvar s = 0; s < QUO_STEPS; s++) begin : g_step
      logic [T_WIDTH:0] rem_in;
      always_comb rem_in = {rem_ff[s][T_WIDTH-1:0], num_ff[s][NUM_WIDTH-1]};
      always_ff @(posedge clock) begin
         if (enable) begin
            div_ff[s+1] <= div_ff[s];
            nz_ff[s+1] <= nz_ff[s];
            num_ff[s+1] <= {num_ff[s][NUM_WIDTH-2:0], 1'b0};
            if (rem_in >= {1'b0, div_ff[s]}) begin
               rem_ff[s+1] <= rem_in - {1'b0, div_ff[s]};
               quo_ff[s+1] <= {quo_ff[s][NUM_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= rem_in;
               quo_ff[s+1] <= {quo_ff[s][NUM_WIDTH-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      sat = quo_ff[QUO_STEPS][NUM_WIDTH-1:RATIO_WIDTH] != '0;
      if (div_ff[QUO_STEPS] == '0) begin
         result.mouth_open = nz_ff[QUO_STEPS];
         result.open_ratio = nz_ff[QUO_STEPS] ? '1 : '0;
      end else begin
         result.mouth_open = sat || (quo_ff[QUO_STEPS][RATIO_WIDTH-1:0] > threshold);
         result.open_ratio = sat ? '1 : quo_ff[QUO_STEPS][RATIO_WIDTH-1:0];
      end
   end
endmodule

// File: verif/mouth_open_detector_top_tb.sv
// Self-checking testbench for mouth_open_detector_top: drives landmark sets and threshold
// writes, predicts each ratio and open flag, and checks every result item in order.
// Depends on mod_pkg, mod_if and the detector RTL.
`timescale 1ns / 100ps

module mouth_open_detector_top_tb;
   import mod_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 100;

   class lip_scoreboard;
      rsp_type            expected_q[$];
      logic [15:0]        threshold;
      int                 mismatches;
      int                 stray_results;
      int                 checked;

      function new();
         threshold = 16'd256;
         mismatches = 0;
         stray_results = 0;
         checked = 0;
      endfunction

      function automatic longint unsigned isqrt(longint unsigned v);
         longint unsigned rem, root, trial;
         rem = 0;
         root = 0;
         for (int i = 21; i >= 0; i--) begin
            rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
               rem = rem - trial;
               root = (root << 1) | 64'd1;
            end else begin
               root = root << 1;
            end
         end
         return root;
      endfunction

      function automatic longint unsigned span(logic [15:0] ax, logic [15:0] ay,
                                               logic [15:0] bx, logic [15:0] by);
         longint unsigned dx, dy;
         dx = (ax > bx) ? ax - bx : bx - ax;
         dy = (ay > by) ? ay - by : by - ay;
         return isqrt((dx * dx + dy * dy) << 8);
      endfunction

      function automatic rsp_type predict_ratio(req_type r);
         longint unsigned d_up, d_low, d_gap, d_cor, t_avg, t_cap, t, q;
         rsp_type e;
         d_up = span(r.upper_outer_x, r.upper_outer_y, r.upper_inner_x, r.upper_inner_y);
         d_low = span(r.lower_outer_x, r.lower_outer_y, r.lower_inner_x, r.lower_inner_y);
         d_gap = span(r.upper_inner_x, r.upper_inner_y, r.lower_inner_x, r.lower_inner_y);
         d_cor = span(r.left_corner_x, r.left_corner_y, r.right_corner_x, r.right_corner_y);
         t_avg = 9 * (d_up + d_low);
         t_cap = 4 * d_cor;
         t = (t_cap < t_avg) ? t_cap : t_avg;
         if (t == 0) begin
            e.mouth_open = (d_gap != 0);
            e.open_ratio = (d_gap != 0) ? 16'hFFFF : 16'h0000;
         end else begin
            q = (d_gap * 4608) / t;
            e.mouth_open = (q > threshold);
            e.open_ratio = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
         end
         return e;
      endfunction

      function void note_request(req_type r);
         expected_q.push_back(predict_ratio(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            stray_results++;
            if (stray_results + mismatches <= 10)
               $display("Result item with nothing expected: open=%0d ratio=%0d",
                        got.mouth_open, got.open_ratio);
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (e.mouth_open !== got.mouth_open || e.open_ratio !== got.open_ratio) begin
            mismatches++;
            if (mismatches + stray_results <= 10)
               $display("Mismatch on result %0d: expected open=%0d ratio=%0d, got open=%0d ratio=%0d",
                        checked, e.mouth_open, e.open_ratio, got.mouth_open, got.open_ratio);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   mod_req_if req_ch ();
   mod_rsp_if rsp_ch ();
   mod_csr_if csr_ch ();

   mouth_open_detector_top DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr(csr_ch)
   );

   lip_scoreboard sb = new();
   bit  sender_idles = 1;
   bit  receiver_stalls = 1;
   bit  long_hold = 0;
   int  sets_sent = 0;
   int  threshold_writes = 0;
   int  quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (!reset) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", sb.pending());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.payload);
   end

   initial begin : receiver
      int n;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = receiver_stalls ? $urandom_range(0, 7) : 0;
         if (long_hold) begin
            long_hold = 0;
            n = 300;
         end
         if (n > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_set(req_type r);
      int n;
      n = sender_idles ? $urandom_range(0, 7) : 0;
      if (n > 0) begin
         req_ch.valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_ch.payload = r;
      req_ch.valid = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(r);
      sets_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_threshold(logic [15:0] value);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_ch.data = value;
      csr_ch.valid = 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.threshold = value;
      threshold_writes++;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   function automatic logic [15:0] near(logic [15:0] base, int spread);
      int v;
      v = int'(base) + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   function automatic req_type mouth_shape(int scale);
      req_type r;
      logic [15:0] cx, cy;
      int gap, lip;
      cx = 16'($urandom_range(0, 65535));
      cy = 16'($urandom_range(0, 65535));
      gap = $urandom_range(0, scale);
      lip = $urandom_range(0, scale / 2);
      r.upper_inner_x = near(cx, scale / 8);
      r.upper_inner_y = near(cy, gap / 2 + 1);
      r.lower_inner_x = near(cx, scale / 8);
      r.lower_inner_y = near(cy, gap / 2 + 1);
      r.upper_outer_x = near(r.upper_inner_x, lip / 4 + 1);
      r.upper_outer_y = near(r.upper_inner_y, lip + 1);
      r.lower_outer_x = near(r.lower_inner_x, lip / 4 + 1);
      r.lower_outer_y = near(r.lower_inner_y, lip + 1);
      r.left_corner_x = near(cx, 2 * scale + 1);
      r.left_corner_y = near(cy, scale / 4 + 1);
      r.right_corner_x = near(cx, 2 * scale + 1);
      r.right_corner_y = near(cy, scale / 4 + 1);
      return r;
   endfunction

   function automatic req_type wild_set();
      req_type r;
      r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      return r;
   endfunction

   task automatic run_random(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 9);
         if (pick < 5) send_set(mouth_shape($urandom_range(1, 4000)));
         else if (pick < 7) send_set(mouth_shape($urandom_range(0, 40)));
         else send_set(wild_set());
      end
   endtask

   initial begin : stimulus
      req_type r;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed sets under the reset threshold of 1.0.
      r = '0;
      send_set(r);
      r.upper_inner_y = 16'd5;
      send_set(r);
      r = '1;
      send_set(r);
      r = '0;
      r.upper_outer_y = 16'd0;
      r.upper_inner_y = 16'd16;
      r.lower_inner_y = 16'd32;
      r.lower_outer_y = 16'd48;
      r.right_corner_x = 16'hFFFF;
      send_set(r);
      r.upper_inner_y = 16'd17;
      send_set(r);
      r.upper_inner_y = 16'd15;
      send_set(r);
      r.right_corner_x = 16'd10;
      send_set(r);
      r = '0;
      r.upper_outer_x = 16'd1;
      r.upper_inner_x = 16'd0;
      r.lower_inner_x = 16'hFFFF;
      r.lower_inner_y = 16'hFFFF;
      r.lower_outer_x = 16'hFFFF;
      r.lower_outer_y = 16'hFFFF;
      r.right_corner_x = 16'hFFFF;
      r.right_corner_y = 16'hFFFF;
      send_set(r);
      r = '0;
      r.upper_outer_x = 16'hFFFF;
      r.upper_outer_y = 16'hFFFF;
      r.lower_outer_x = 16'hFFFF;
      r.lower_inner_x = 16'hFFFF;
      r.lower_inner_y = 16'hFFFF;
      r.left_corner_y = 16'hFFFF;
      send_set(r);
      r = {6{32'hAAAA_5555}};
      send_set(r);
      r = {6{32'h5555_AAAA}};
      send_set(r);
      for (int i = 0; i < 8; i++) send_set(mouth_shape(300));

      write_threshold(16'd0);
      run_random(150);
      long_hold = 1;
      run_random(100);
      write_threshold(16'hFFFF);
      run_random(150);
      write_threshold(16'($urandom_range(1, 1024)));
      run_random(100);
      wait_drained();
      run_random(150);
      write_threshold(16'($urandom_range(0, 65535)));
      run_random(150);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d landmark sets over %0d threshold settings, checked %0d results.",
               sets_sent, threshold_writes + 1, sb.checked);
      $display("Covered zero divisors, saturation, corner capping, ties and back-pressure.");
      if (sb.mismatches == 0 && sb.stray_results == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d unexpected results", sb.mismatches, sb.stray_results);
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
